[hdl/glucas_pkg.sv]
// Shared types, constants and the Lucas number table for the greedy Lucas decomposer.
`timescale 1ns / 1ps

package glucas_pkg;

  // Widths of the item fields
  localparam int TARGET_W = 32;
  localparam int INDEX_W  = 6;
  localparam int LIMIT_W  = 6;

  // Term limit bounds and reset value
  localparam logic [LIMIT_W-1:0] TERM_LIMIT_RST = 6'd10;
  localparam logic [LIMIT_W-1:0] TERM_CAP       = 6'd32;
  localparam logic [LIMIT_W-1:0] TERM_MIN       = 6'd1;

  // Highest table index searched, clamped to the last entry that fits 32 bits
  localparam int TABLE_MAX = 46;
  localparam int TOP_INDEX = 40;
  localparam int TOP_LIM   = (TOP_INDEX > TABLE_MAX) ? TABLE_MAX : TOP_INDEX;

  // Lucas numbers L_0 .. L_46
  localparam logic [TARGET_W-1:0] LUCAS_TAB [TABLE_MAX+1] = '{
    32'd2, 32'd1, 32'd3, 32'd4, 32'd7, 32'd11, 32'd18, 32'd29, 32'd47, 32'd76,
    32'd123, 32'd199, 32'd322, 32'd521, 32'd843, 32'd1364, 32'd2207, 32'd3571,
    32'd5778, 32'd9349, 32'd15127, 32'd24476, 32'd39603, 32'd64079, 32'd103682,
    32'd167761, 32'd271443, 32'd439204, 32'd710647, 32'd1149851, 32'd1860498,
    32'd3010349, 32'd4870847, 32'd7881196, 32'd12752043, 32'd20633239,
    32'd33385282, 32'd54018521, 32'd87403803, 32'd141422324, 32'd228826127,
    32'd370248451, 32'd599074578, 32'd969323029, 32'd1568397607,
    32'd2537720636, 32'd4106118243
  };

  // One queued decomposition job
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [LIMIT_W-1:0]  limit;
  } job_t;

endpackage

[hdl/greedy_lucas_decomposer.sv]
// Top level of the greedy Lucas decomposer: front end, job queue and term engine.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_target
//   out      output     out_valid / out_stall  out_term_index, out_term_value,
//                                              out_remaining_after, out_last_term
//   cfg      input      cfg_wr_en              cfg_wr_data (term limit)
//
// The term engine loads a job, then produces its terms in order from the single
// compare-and-subtract stage, stalling while out_stall holds a pending term.
// A zero target is accepted and dropped by the front end and produces no items.
// The front end keeps accepting into a two-entry queue while the engine works.
// Reset (rst_n low, synchronous) empties the queue, idles the engine, sets the term limit
// to 10. out_stall freezes the engine while a term is held; in_stall rises on a full queue.
`timescale 1ns / 1ps

module greedy_lucas_decomposer import glucas_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [LIMIT_W-1:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [TARGET_W-1:0] in_target,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [INDEX_W-1:0]  out_term_index,
  output logic [TARGET_W-1:0] out_term_value,
  output logic [TARGET_W-1:0] out_remaining_after,
  output logic                out_last_term
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  glucas_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_target  (in_target),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  glucas_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .pop_job (pop_job),
    .empty   (q_empty)
  );

  glucas_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_job              (pop_job),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_term_index     (out_term_index),
    .out_term_value     (out_term_value),
    .out_remaining_after(out_remaining_after),
    .out_last_term      (out_last_term)
  );

endmodule

[hdl/glucas_front.sv]
// Front end: holds the term limit register, accepts targets and queues nonzero ones.
`timescale 1ns / 1ps

module glucas_front import glucas_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [LIMIT_W-1:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [TARGET_W-1:0] in_target,
  input  logic                q_full,
  output logic                q_push,
  output job_t                q_job
);

  logic [LIMIT_W-1:0] term_lim_r;
  logic [LIMIT_W-1:0] limit;

  // Hold the term limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_lim_r <= TERM_LIMIT_RST;
    end else if (cfg_wr_en) begin
      term_lim_r <= cfg_wr_data;
    end
  end

  // Clamp the limit into one .. cap
  always_comb begin
    limit = term_lim_r;
    if (term_lim_r == '0) begin
      limit = TERM_MIN;
    end else if (term_lim_r > TERM_CAP) begin
      limit = TERM_CAP;
    end
  end

  // Accept while the queue has room; drop zero targets, they yield no terms
  assign in_stall     = q_full;
  assign q_push       = in_valid && !q_full && (in_target != '0);
  assign q_job.target = in_target;
  assign q_job.limit  = limit;

endmodule

[hdl/glucas_fifo.sv]
// Two-entry job queue between the front end and the term engine.
`timescale 1ns / 1ps

module glucas_fifo import glucas_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign pop_job = mem_r[rd_ptr_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hdl/glucas_back.sv]
// Term engine: picks one greedy Lucas term per cycle unless a held result is stalled, and drives the result register.
`timescale 1ns / 1ps

module glucas_back import glucas_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  job_t                q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [INDEX_W-1:0]  out_term_index,
  output logic [TARGET_W-1:0] out_term_value,
  output logic [TARGET_W-1:0] out_remaining_after,
  output logic                out_last_term
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t              state_r;
  logic [TARGET_W-1:0] rem_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [LIMIT_W-1:0]  count_r;
  logic                out_valid_r;
  logic [INDEX_W-1:0]  idx_r;
  logic [TARGET_W-1:0] val_r;
  logic [TARGET_W-1:0] rem_out_r;
  logic                last_r;

  logic [INDEX_W-1:0]  pick_idx;
  logic [TARGET_W-1:0] pick_val;
  logic [TARGET_W-1:0] rem_nxt;
  logic [LIMIT_W-1:0]  count_nxt;
  logic                last_nxt;
  logic                step;

  // Largest value among L_0 .. L_TOP_LIM not above the remainder; L_0 = 2 sits between L_1 and L_2
  always_comb begin
    pick_idx = (rem_r >= TARGET_W'(2)) ? INDEX_W'(0) : INDEX_W'(1);
    for (int i = 2; i <= TOP_LIM; i++) begin
      if (LUCAS_TAB[i] <= rem_r) begin
        pick_idx = INDEX_W'(i);
      end
    end
    pick_val  = LUCAS_TAB[pick_idx];
    rem_nxt   = rem_r - pick_val;
    count_nxt = count_r + LIMIT_W'(1);
    last_nxt  = (rem_nxt == '0) || (count_nxt >= limit_r);
  end

  // Emit a term whenever the result register is free or being taken
  assign step  = (state_r == ST_RUN) && (!out_valid_r || !out_stall);
  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  // Sequence jobs, walk the remainder down one term at a time, hold the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      limit_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      val_r       <= '0;
      rem_out_r   <= '0;
      last_r      <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            state_r <= ST_RUN;
            rem_r   <= q_job.target;
            limit_r <= q_job.limit;
            count_r <= '0;
          end
        end
        ST_RUN: begin
          if (step) begin
            out_valid_r <= 1'b1;
            rem_r       <= rem_nxt;
            count_r     <= count_nxt;
            idx_r       <= pick_idx;
            val_r       <= pick_val;
            rem_out_r   <= rem_nxt;
            last_r      <= last_nxt;
            if (last_nxt) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_term_index      = idx_r;
  assign out_term_value      = val_r;
  assign out_remaining_after = rem_out_r;
  assign out_last_term       = last_r;

endmodule
